/* sv/scbp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package scbp_pkg;
   localparam int NUM_CLASSES_DEF = 9;
   localparam int FREE_DEPTH_DEF  = 4;
   localparam int MAX_IDS_DEF     = 4096;

   localparam int ID_W    = 12;
   localparam int LIMIT_W = 29;
   localparam int SIZE_W  = 32;
   localparam int CLS_W   = 4;
   localparam int ALLOC_W = 23;
   localparam int ACT_W   = 3;
   localparam int KIND_W  = 2;

   localparam logic [LIMIT_W-1:0] POOL_LIMIT_RESET = LIMIT_W'(64 * 1024 * 1024);

   localparam logic [KIND_W-1:0] KIND_ACQUIRE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEANUP = 2'd2;

   localparam logic [ACT_W-1:0] ACT_HIT    = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ALLOC  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
   localparam logic [ACT_W-1:0] ACT_KEPT   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DONE   = 3'd4;

   // Byte size of class c: 64 * 4^c, wide enough for sixteen classes.
   function automatic logic [37:0] class_bytes(input logic [CLS_W-1:0] c);
      logic [37:0] r;
      r = 38'd64 << {c, 1'b0};
      return r;
   endfunction
endpackage
`default_nettype wire

/* sv/size_class_buffer_pool.sv */
// Size-class buffer pool manager.
// req_ carries one operation word, its kind in req_tuser: acquire, release or
// cleanup. A word of the unused kind is taken and dropped.
// rsp_ returns result words with the action in rsp_tuser; rsp_tlast marks the
// last word of an operation. csr_ writes the pool byte budget; write it only
// while no operation is in work.
// Acquire and release pass through a read step that reads the ownership table
// and the class FIFO, an execute step that updates both and loads the result
// register, a step in which the result word is offered, and the idle step
// with req_tready high. The result word is valid once the execute step has
// loaded the result register. Cleanup walks the classes from the largest down
// with one shared compare. req_tready is low while an operation is in work.
// After reset the ownership table is swept clear, one entry per cycle, before
// the first operation is taken. When the receiver stalls, the result register
// holds and the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
module size_class_buffer_pool #(
   parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
   parameter int FREE_DEPTH  = scbp_pkg::FREE_DEPTH_DEF,
   parameter int MAX_IDS     = scbp_pkg::MAX_IDS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // min_size[31:0], buffer_id[43:32], fresh_id[55:44], cleanup_limit[84:56],
   // zero pad to 88
   input  wire logic [87:0] req_tdata,
   // kind[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_id[11:0], size_class[15:12], alloc_bytes[38:16], pool_bytes[67:39],
   // zero pad to 72
   output logic [71:0]      rsp_tdata,
   // action[2:0]
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [28:0] csr_data
);
   localparam int CW  = scbp_pkg::CLS_W;
   localparam int IW  = scbp_pkg::ID_W;
   localparam int LW  = scbp_pkg::LIMIT_W;
   localparam int AW  = scbp_pkg::ACT_W;
   localparam int DW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
   localparam int NW  = $clog2(FREE_DEPTH + 1);
   localparam int TW  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
   localparam int SW  = $clog2(MAX_IDS + 1);
   localparam int FIX = NUM_CLASSES * FREE_DEPTH;
   localparam int FW  = (FIX > 1) ? $clog2(FIX) : 1;
   localparam logic [CW-1:0] TOP_CLASS = CW'(NUM_CLASSES - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_CLEAN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;
   localparam logic [2:0] ST_CPOP  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [SW-1:0] sweep_ff, sweep_in;
   logic [LW-1:0] limit_ff, limit_in;
   logic [LW-1:0] pooled_ff, pooled_in;
   logic [DW-1:0] head_ff [NUM_CLASSES];
   logic [NW-1:0] count_ff [NUM_CLASSES];
   logic [IW-1:0] fifo_mem [FIX];
   logic [IW-1:0] pop_rd_ff;
   logic [4:0] own_mem [MAX_IDS];
   logic [4:0] own_rd_ff;

   logic [scbp_pkg::KIND_W-1:0] kind_ff;
   logic [IW-1:0] id_ff, fresh_ff;
   logic [LW-1:0] clim_ff;
   logic [CW-1:0] cls_ff, cls_in;
   logic [AW-1:0] act_ff;
   logic [IW-1:0] oid_ff;
   logic [CW-1:0] ocls_ff;
   logic [scbp_pkg::ALLOC_W-1:0] oalloc_ff;
   logic [LW-1:0] opool_ff;
   logic olast_ff, ovalid_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tuser  = act_ff;
   assign rsp_tdata  = {4'b0000, opool_ff, oalloc_ff, ocls_ff, oid_ff};

   wire acc = req_tvalid && req_tready;
   wire [scbp_pkg::KIND_W-1:0] r_kind = req_tuser;
   wire [31:0] r_size  = req_tdata[31:0];

   // First class that fits, by a priority search over constant sizes.
   always_comb begin
      cls_in = TOP_CLASS;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if ({6'd0, r_size} <= scbp_pkg::class_bytes(CW'(i))) cls_in = CW'(i);
      end
   end

   wire [CW-1:0] own_cls = (own_rd_ff[3:0] > TOP_CLASS) ? TOP_CLASS : own_rd_ff[3:0];
   // A release works on the class the buffer is owned in.
   wire [CW-1:0] cur_cls = (kind_ff == scbp_pkg::KIND_RELEASE) ? own_cls : cls_ff;

   // Shared unit: slot index and pooled-byte arithmetic for the current class.
   wire [37:0] cb     = scbp_pkg::class_bytes(cur_cls);
   wire [LW-1:0] cbl  = cb[LW-1:0];
   wire [NW-1:0] cnt  = count_ff[cur_cls];
   wire [DW-1:0] hd   = head_ff[cur_cls];
   wire [DW:0] tail_w = {1'b0, hd} + (DW+1)'(cnt);
   wire [DW-1:0] tail = (tail_w >= (DW+1)'(FREE_DEPTH)) ?
                        DW'(tail_w - (DW+1)'(FREE_DEPTH)) : tail_w[DW-1:0];
   wire [DW-1:0] hd_nx = ({1'b0, hd} + 1'b1 == (DW+1)'(FREE_DEPTH)) ? '0 : DW'(hd + 1'b1);
   wire [FW-1:0] slot_base = FW'(cur_cls * FREE_DEPTH);
   wire [FW-1:0] rd_addr = FW'(slot_base + FW'(hd));
   wire [FW-1:0] wr_addr = FW'(slot_base + FW'(tail));
   wire [38:0] add_sum  = {10'd0, pooled_ff} + {1'b0, cb};
   wire [LW-1:0] clim_eff = (clim_ff != '0) ? clim_ff : limit_ff;
   wire out_free = !ovalid_ff || rsp_tready;
   wire own_valid = own_rd_ff[4] && (32'(id_ff) < 32'(MAX_IDS));
   wire keep_ok = own_valid && add_sum <= {10'd0, limit_ff} && cnt < NW'(FREE_DEPTH);
   wire clean_pop = (cnt != '0) && (pooled_ff > clim_eff);

   always_comb begin
      state_in  = state_ff;
      sweep_in  = sweep_ff;
      limit_in  = (csr_valid && csr_ready) ? csr_data : limit_ff;
      pooled_in = pooled_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            sweep_in = SW'(sweep_ff + 1'b1);
            if (sweep_ff == SW'(MAX_IDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE:  if (acc) begin
            priority if (r_kind == scbp_pkg::KIND_CLEANUP) state_in = ST_CLEAN;
            else if (r_kind == scbp_pkg::KIND_RELEASE) state_in = ST_READ;
            else if (r_kind == scbp_pkg::KIND_ACQUIRE) state_in = ST_READ;
            else state_in = ST_IDLE;
         end
         ST_READ:  state_in = ST_EXEC;
         ST_EXEC:  if (out_free) begin
            state_in = ST_OUT;
            if (kind_ff == scbp_pkg::KIND_ACQUIRE) begin
               if (cnt != '0) pooled_in = pooled_ff - cbl;
            end else if (keep_ok) begin
               pooled_in = add_sum[LW-1:0];
            end
         end
         ST_CLEAN: begin
            if (clean_pop) state_in = ST_CPOP;
            else if (cls_ff == '0) state_in = ST_DONE;
         end
         ST_CPOP:  if (out_free) begin
            pooled_in = pooled_ff - cbl;
            state_in  = ST_CLEAN;
         end
         ST_DONE:  if (out_free) state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         sweep_ff  <= '0;
         limit_ff  <= scbp_pkg::POOL_LIMIT_RESET;
         pooled_ff <= '0;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         sweep_ff  <= sweep_in;
         limit_ff  <= limit_in;
         pooled_ff <= pooled_in;
         if (rsp_tready) ovalid_ff <= 1'b0;
         if (state_ff == ST_EXEC && out_free) begin
            ovalid_ff <= 1'b1;
            if (kind_ff == scbp_pkg::KIND_ACQUIRE) begin
               if (cnt != '0) begin
                  head_ff[cur_cls]  <= hd_nx;
                  count_ff[cur_cls] <= NW'(cnt - 1'b1);
               end
            end else if (keep_ok) begin
               count_ff[cur_cls] <= NW'(cnt + 1'b1);
            end
         end
         if (state_ff == ST_CPOP && out_free) begin
            ovalid_ff <= 1'b1;
            head_ff[cur_cls]  <= hd_nx;
            count_ff[cur_cls] <= NW'(cnt - 1'b1);
         end
         if (state_ff == ST_DONE && out_free) ovalid_ff <= 1'b1;
      end
   end

   // Payload, FIFO storage and ownership table.
   always_ff @(posedge clock) begin
      if (acc) begin
         kind_ff  <= r_kind;
         id_ff    <= req_tdata[43:32];
         fresh_ff <= req_tdata[55:44];
         clim_ff  <= req_tdata[84:56];
         cls_ff   <= (r_kind == scbp_pkg::KIND_CLEANUP) ? TOP_CLASS : cls_in;
      end
      if (state_ff == ST_READ) own_rd_ff <= own_mem[TW'(id_ff)];
      // The oldest id of the current class is fetched into a register ahead of its use.
      if (state_ff == ST_READ || state_ff == ST_CLEAN) pop_rd_ff <= fifo_mem[rd_addr];
      if (state_ff == ST_CLEAR) own_mem[sweep_ff[TW-1:0]] <= '0;
      if (state_ff == ST_EXEC && out_free) begin
         act_ff    <= scbp_pkg::ACT_DELETE;
         olast_ff  <= 1'b1;
         oalloc_ff <= '0;
         opool_ff  <= pooled_in;
         if (kind_ff == scbp_pkg::KIND_ACQUIRE) begin
            ocls_ff <= cls_ff;
            if (cnt != '0) begin
               act_ff <= scbp_pkg::ACT_HIT;
               oid_ff <= pop_rd_ff;
               if (32'(pop_rd_ff) < 32'(MAX_IDS)) own_mem[TW'(pop_rd_ff)] <= {1'b1, cls_ff};
            end else begin
               act_ff    <= scbp_pkg::ACT_ALLOC;
               oid_ff    <= fresh_ff;
               oalloc_ff <= cb[scbp_pkg::ALLOC_W-1:0];
               if (32'(fresh_ff) < 32'(MAX_IDS))
                  own_mem[TW'(fresh_ff)] <= {1'b1, cls_ff};
            end
         end else begin
            oid_ff  <= id_ff;
            ocls_ff <= own_valid ? own_cls : '0;
            if (own_valid) begin
               own_mem[TW'(id_ff)] <= '0;
               if (keep_ok) begin
                  act_ff <= scbp_pkg::ACT_KEPT;
                  fifo_mem[wr_addr] <= id_ff;
               end
            end
         end
      end
      if (state_ff == ST_CLEAN && !clean_pop && cls_ff != '0) begin
         cls_ff <= CW'(cls_ff - 1'b1);
      end
      if (state_ff == ST_CPOP && out_free) begin
         act_ff    <= scbp_pkg::ACT_DELETE;
         oid_ff    <= pop_rd_ff;
         ocls_ff   <= cls_ff;
         oalloc_ff <= '0;
         opool_ff  <= pooled_in;
         olast_ff  <= 1'b0;
      end
      if (state_ff == ST_DONE && out_free) begin
         act_ff    <= scbp_pkg::ACT_DONE;
         oid_ff    <= '0;
         ocls_ff   <= '0;
         oalloc_ff <= '0;
         opool_ff  <= pooled_ff;
         olast_ff  <= 1'b1;
      end
   end
endmodule
`default_nettype wire

/* sv/scbp_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module scbp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [1:0]  req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata,
   input wire logic [2:0]  rsp_tuser,
   input wire logic        rsp_tlast
);
   // A stalled result word holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed under stall");
   // No new operation is taken while a result word is pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("accepted while result pending");
   // Only the cleanup done word and single results end an operation.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == scbp_pkg::ACT_DONE |-> rsp_tlast)
      else $error("cleanup done without last");
   // Ready drops after a real operation is accepted.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == scbp_pkg::KIND_ACQUIRE
         || req_tuser == scbp_pkg::KIND_RELEASE || req_tuser == scbp_pkg::KIND_CLEANUP)
      |=> !req_tready)
      else $error("ready stayed high after accept");
endmodule
bind size_class_buffer_pool scbp_checker u_scbp_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .req_tuser(req_tuser), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast));
`default_nettype wire
